// ===== hdl/khc_pkg.sv =====
// Shared types, constants and helpers for the 1-D k-means hotness classifier.
`default_nettype none
package khc_pkg;
  localparam int VAL_W  = 30;
  localparam int WORD_W = 32;
  localparam int RAND_W = 64;
  localparam int DIV_W  = 64;

  localparam logic [VAL_W-1:0] SAMPLE_ALL_ONES = 30'h3FFF_FFFF;

  localparam logic [1:0] MODE_LOAD     = 2'd0;
  localparam logic [1:0] MODE_RUN      = 2'd1;
  localparam logic [1:0] MODE_CLASSIFY = 2'd2;

  localparam logic [1:0] KIND_CENTER = 2'd0;
  localparam logic [1:0] KIND_CLASS  = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [1:0] TEMP_HOT  = 2'd0;
  localparam logic [1:0] TEMP_WARM = 2'd1;
  localparam logic [1:0] TEMP_COLD = 2'd2;

  typedef enum logic [1:0] {PASS_TOTAL, PASS_PICK, PASS_ASSIGN} pass_kind_t;
  typedef enum logic [1:0] {DIV_FIRST, DIV_SEED, DIV_MEAN} div_sel_t;

  typedef struct packed {
    logic       pass_start;
    pass_kind_t pass_kind;
    logic       div_start;
    div_sel_t   div_sel;
    logic       rd_first;
    logic       load_c0;
    logic       fill_same;
    logic       set_ck;
    logic       round_clr;
    logic       round_inc;
    logic       clr_changed;
    logic       upd_mean;
    logic       sort;
    logic       emit;
    logic       clear_count;
    logic [1:0] kidx;
    logic [1:0] cidx;
    logic [1:0] slot;
  } khc_cmd_t;

  typedef struct packed {
    logic       count_zero;
    logic       div_done;
    logic       pass_done;
    logic       total_zero;
    logic [2:0] members_zero;
    logic       changed;
    logic       round_limit;
    logic       kc3;
  } khc_status_t;

  function automatic logic [VAL_W-1:0] absdiff30(input logic [VAL_W-1:0] a,
                                                 input logic [VAL_W-1:0] b);
    return (a < b) ? (b - a) : (a - b);
  endfunction

  function automatic logic [WORD_W-1:0] absdiff32(input logic [WORD_W-1:0] a,
                                                  input logic [WORD_W-1:0] b);
    return (a < b) ? (b - a) : (a - b);
  endfunction
endpackage
`default_nettype wire

// ===== hdl/khc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module khc_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write one entry, read one entry per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hdl/khc_div.sv =====
// Restoring divider, one quotient bit per cycle; quotient and remainder held.
`default_nettype none
module khc_div (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [khc_pkg::DIV_W-1:0] dividend,
  input  wire logic [khc_pkg::DIV_W-1:0] divisor,
  output logic                           done,
  output logic      [khc_pkg::DIV_W-1:0] quot,
  output logic      [khc_pkg::DIV_W-1:0] rem
);
  localparam int W  = khc_pkg::DIV_W;
  localparam int CW = $clog2(W);

  logic [W-1:0]  dvs;
  logic [CW-1:0] cnt;
  logic          running;
  logic [W:0]    rem_sh;
  logic          fits;

  assign rem_sh = {rem, quot[W-1]};
  assign fits   = rem_sh >= {1'b0, dvs};

  // shift one dividend bit in per cycle, subtract when it fits
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
        rem     <= '0;
        quot    <= dividend;
        dvs     <= divisor;
      end else if (running) begin
        rem  <= fits ? W'(rem_sh - {1'b0, dvs}) : rem_sh[W-1:0];
        quot <= {quot[W-2:0], fits};
        cnt  <= cnt + 1'b1;
        if (cnt == CW'(W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== hdl/khc_ctrl.sv =====
// Run sequencer: seeding, refinement rounds, sort and center emission.
`default_nettype none
module khc_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [1:0]           mode,
  input  wire khc_pkg::khc_status_t sts,
  output khc_pkg::khc_cmd_t         cmd,
  output logic                      busy
);
  typedef enum logic [4:0] {
    S_IDLE, S_F_GO, S_F_WAIT, S_F_RD, S_F_LD, S_T_GO, S_T_WAIT, S_T_CHK,
    S_S_GO, S_S_WAIT, S_P_GO, S_P_WAIT, S_P_SET, S_R_GO, S_R_WAIT,
    S_M_CHK, S_M_WAIT, S_R_END, S_SORT, S_EMIT
  } state_t;

  state_t     state;
  logic [1:0] kidx;
  logic [1:0] cidx;
  logic [1:0] slot;
  logic [1:0] kc_last;

  assign busy    = state != S_IDLE;
  assign kc_last = sts.kc3 ? 2'd2 : 2'd1;

  // decode commands from the current state
  always_comb begin
    cmd            = '0;
    cmd.pass_kind  = khc_pkg::PASS_TOTAL;
    cmd.div_sel    = khc_pkg::DIV_FIRST;
    cmd.kidx       = kidx;
    cmd.cidx       = cidx;
    cmd.slot       = slot;
    unique case (state)
      S_F_GO: begin
        cmd.div_start = 1'b1;
        cmd.round_clr = 1'b1;
      end
      S_F_RD: cmd.rd_first = 1'b1;
      S_F_LD: cmd.load_c0 = 1'b1;
      S_T_GO: cmd.pass_start = 1'b1;
      S_T_CHK: cmd.fill_same = sts.total_zero;
      S_S_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = khc_pkg::DIV_SEED;
      end
      S_P_GO: begin
        cmd.pass_start = 1'b1;
        cmd.pass_kind  = khc_pkg::PASS_PICK;
      end
      S_P_SET: cmd.set_ck = 1'b1;
      S_R_GO: begin
        cmd.pass_start  = 1'b1;
        cmd.pass_kind   = khc_pkg::PASS_ASSIGN;
        cmd.round_inc   = 1'b1;
        cmd.clr_changed = 1'b1;
      end
      S_M_CHK: begin
        cmd.div_start = !sts.members_zero[cidx];
        cmd.div_sel   = khc_pkg::DIV_MEAN;
      end
      S_M_WAIT: begin
        cmd.div_sel  = khc_pkg::DIV_MEAN;
        cmd.upd_mean = sts.div_done;
      end
      S_SORT: cmd.sort = 1'b1;
      S_EMIT: begin
        cmd.emit        = 1'b1;
        cmd.clear_count = slot == kc_last;
      end
      default: ;
    endcase
  end

  // advance state and loop counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      kidx  <= '0;
      cidx  <= '0;
      slot  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start && mode == khc_pkg::MODE_RUN && !sts.count_zero) begin
            state <= S_F_GO;
          end
        end
        S_F_GO:   state <= S_F_WAIT;
        S_F_WAIT: if (sts.div_done) state <= S_F_RD;
        S_F_RD:   state <= S_F_LD;
        S_F_LD: begin
          kidx  <= 2'd1;
          state <= S_T_GO;
        end
        S_T_GO:   state <= S_T_WAIT;
        S_T_WAIT: if (sts.pass_done) state <= S_T_CHK;
        S_T_CHK:  state <= sts.total_zero ? S_R_GO : S_S_GO;
        S_S_GO:   state <= S_S_WAIT;
        S_S_WAIT: if (sts.div_done) state <= S_P_GO;
        S_P_GO:   state <= S_P_WAIT;
        S_P_WAIT: if (sts.pass_done) state <= S_P_SET;
        S_P_SET: begin
          if (kidx == kc_last) begin
            state <= S_R_GO;
          end else begin
            kidx  <= kidx + 2'd1;
            state <= S_T_GO;
          end
        end
        S_R_GO: begin
          cidx  <= '0;
          state <= S_R_WAIT;
        end
        S_R_WAIT: if (sts.pass_done) state <= S_M_CHK;
        S_M_CHK: begin
          if (!sts.members_zero[cidx]) begin
            state <= S_M_WAIT;
          end else if (cidx == kc_last) begin
            state <= S_R_END;
          end else begin
            cidx <= cidx + 2'd1;
          end
        end
        S_M_WAIT: begin
          if (sts.div_done) begin
            if (cidx == kc_last) begin
              state <= S_R_END;
            end else begin
              cidx  <= cidx + 2'd1;
              state <= S_M_CHK;
            end
          end
        end
        S_R_END: state <= (sts.changed && !sts.round_limit) ? S_R_GO : S_SORT;
        S_SORT: begin
          slot  <= '0;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (slot == kc_last) begin
            state <= S_IDLE;
          end else begin
            slot <= slot + 2'd1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== hdl/khc_dp.sv =====
// Datapath: sample store, pass pipeline, centers, divider and result register.
`default_nettype none
module khc_dp #(
  parameter int MAX_SAMPLES = 4096,
  parameter int MAX_ROUNDS  = 1000
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic                       busy,
  input  wire logic [1:0]                 mode,
  input  wire logic [khc_pkg::WORD_W-1:0] sample_value,
  input  wire logic [khc_pkg::RAND_W-1:0] rand_first,
  input  wire logic [khc_pkg::RAND_W-1:0] rand_second,
  input  wire logic [khc_pkg::RAND_W-1:0] rand_third,
  input  wire logic                       cfg_we,
  input  wire logic [1:0]                 cfg_data,
  input  wire khc_pkg::khc_cmd_t          cmd,
  output khc_pkg::khc_status_t            sts,
  output logic                            result_valid,
  output logic [1:0]                      result_kind,
  output logic [khc_pkg::VAL_W-1:0]       center_value,
  output logic [1:0]                      center_slot,
  output logic [1:0]                      temperature_class,
  output logic [9:0]                      rounds_used,
  output logic                            last
);
  localparam int VW = khc_pkg::VAL_W;
  localparam int DW = khc_pkg::DIV_W;
  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int TW = VW + 1 + CW;
  localparam int SW = VW + CW;
  localparam int RW = $clog2(MAX_ROUNDS + 1);

  logic          accept;
  logic [1:0]    cc;
  logic          kc3;
  logic [CW-1:0] count;
  logic [VW-1:0] ld_val;
  logic          ld_we;
  logic [khc_pkg::RAND_W-1:0] r1, r2, r3;
  logic [VW-1:0] c [3];
  logic [RW-1:0] rounds;
  logic          changed;

  assign accept = start && !busy;
  assign kc3    = cc == 2'd3;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      cc <= 2'd2;
    end else if (cfg_we) begin
      cc <= cfg_data;
    end
  end

  // sample loads
  assign ld_val = sample_value[khc_pkg::WORD_W-1:2];
  assign ld_we  = accept && mode == khc_pkg::MODE_LOAD && ld_val != '0 &&
                  ld_val != khc_pkg::SAMPLE_ALL_ONES && count != CW'(MAX_SAMPLES);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.clear_count) begin
      count <= '0;
    end else if (ld_we) begin
      count <= count + 1'b1;
    end
  end

  // hold the run's random words
  always_ff @(posedge clk) begin
    if (accept && mode == khc_pkg::MODE_RUN) begin
      r1 <= rand_first;
      r2 <= rand_second;
      r3 <= rand_third;
    end
  end

  // pass issue stage
  logic                    issuing;
  logic [CW-1:0]           iss_idx;
  khc_pkg::pass_kind_t     pkind;
  logic [AW-1:0]           raddr;
  logic [VW-1:0]           ram_q;
  logic                    rd_vld, rd_last;
  logic [DW-1:0]           div_q, div_r;
  logic                    div_done;

  assign raddr = cmd.rd_first ? div_r[AW-1:0] : iss_idx[AW-1:0];

  khc_ram #(.WIDTH(VW), .DEPTH(MAX_SAMPLES)) u_store (
    .clk  (clk),
    .we   (ld_we),
    .waddr(count[AW-1:0]),
    .wdata(ld_val),
    .raddr(raddr),
    .rdata(ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      issuing <= 1'b0;
      rd_vld  <= 1'b0;
      rd_last <= 1'b0;
    end else begin
      rd_vld  <= issuing;
      rd_last <= issuing && iss_idx == count - 1'b1;
      if (cmd.pass_start) begin
        issuing <= 1'b1;
        iss_idx <= '0;
        pkind   <= cmd.pass_kind;
      end else if (issuing) begin
        iss_idx <= iss_idx + 1'b1;
        if (iss_idx == count - 1'b1) begin
          issuing <= 1'b0;
        end
      end
    end
  end

  // stage 1: seeding distance and nearest center
  logic [VW-1:0] d0, d1, d2;
  logic [VW:0]   dsum;
  logic [1:0]    pos;
  logic          s1_vld, s1_last;
  logic [VW:0]   s1_d;
  logic [1:0]    s1_pos;
  logic [VW-1:0] s1_s;

  always_comb begin
    d0   = khc_pkg::absdiff30(c[0], ram_q);
    d1   = khc_pkg::absdiff30(c[1], ram_q);
    d2   = khc_pkg::absdiff30(c[2], ram_q);
    dsum = {1'b0, d0} + ((cmd.kidx == 2'd2) ? {1'b0, d1} : '0);
    pos  = 2'd0;
    if (d1 < d0) begin
      pos = 2'd1;
    end
    if (kc3 && d2 < ((d1 < d0) ? d1 : d0)) begin
      pos = 2'd2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld  <= 1'b0;
      s1_last <= 1'b0;
    end else begin
      s1_vld  <= rd_vld;
      s1_last <= rd_vld && rd_last;
    end
    s1_d   <= dsum;
    s1_pos <= pos;
    s1_s   <= ram_q;
  end

  // stage 2: accumulate by pass kind
  logic [TW-1:0] total, run_sum, run_next;
  logic          found;
  logic [VW-1:0] pick;
  logic [SW-1:0] sums [3];
  logic [CW-1:0] members [3];
  logic          pass_done;

  assign run_next = run_sum + TW'(s1_d);

  always_ff @(posedge clk) begin
    if (rst) begin
      pass_done <= 1'b0;
    end else begin
      pass_done <= s1_vld && s1_last;
    end
    if (cmd.pass_start) begin
      total   <= '0;
      run_sum <= '0;
      found   <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        sums[i]    <= '0;
        members[i] <= '0;
      end
    end else if (s1_vld) begin
      case (pkind)
        khc_pkg::PASS_TOTAL: total <= total + TW'(s1_d);
        khc_pkg::PASS_PICK: begin
          run_sum <= run_next;
          if (!found) begin
            pick <= s1_s;
            if (run_next >= div_r[TW-1:0]) begin
              found <= 1'b1;
            end
          end
        end
        khc_pkg::PASS_ASSIGN: begin
          sums[s1_pos]    <= sums[s1_pos] + SW'(s1_s);
          members[s1_pos] <= members[s1_pos] + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // shared divider operand select
  logic [DW-1:0] dvd, dvs;

  always_comb begin
    case (cmd.div_sel)
      khc_pkg::DIV_SEED: begin
        dvd = (cmd.kidx == 2'd2) ? r3 : r2;
        dvs = DW'(total);
      end
      khc_pkg::DIV_MEAN: begin
        dvd = DW'(sums[cmd.cidx]);
        dvs = DW'(members[cmd.cidx]);
      end
      default: begin
        dvd = (accept && mode == khc_pkg::MODE_RUN) ? rand_first : r1;
        dvs = DW'(count);
      end
    endcase
  end

  khc_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.div_start),
    .dividend(dvd),
    .divisor (dvs),
    .done    (div_done),
    .quot    (div_q),
    .rem     (div_r)
  );

  // centers: seed, refine, sort
  logic [VW-1:0] t0, t1, t2, tx;
  logic [VW-1:0] mean;

  assign mean = div_q[VW-1:0];

  always_comb begin
    t0 = c[0];
    t1 = c[1];
    t2 = c[2];
    if (t0 > t1) begin
      tx = t0; t0 = t1; t1 = tx;
    end
    if (kc3) begin
      if (t1 > t2) begin
        tx = t1; t1 = t2; t2 = tx;
      end
      if (t0 > t1) begin
        tx = t0; t0 = t1; t1 = tx;
      end
    end else begin
      t2 = khc_pkg::SAMPLE_ALL_ONES;
    end
    tx = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        c[i] <= '0;
      end
      changed <= 1'b0;
      rounds  <= '0;
    end else begin
      if (cmd.round_clr) begin
        rounds <= '0;
      end else if (cmd.round_inc) begin
        rounds <= rounds + 1'b1;
      end
      if (cmd.clr_changed) begin
        changed <= 1'b0;
      end
      if (cmd.load_c0) begin
        c[0] <= ram_q;
      end
      if (cmd.fill_same) begin
        c[1] <= c[0];
        if (kc3) begin
          c[2] <= c[0];
        end
      end
      if (cmd.set_ck) begin
        c[cmd.kidx] <= pick;
      end
      if (cmd.upd_mean && div_q[DW-1:0] != DW'(c[cmd.cidx])) begin
        c[cmd.cidx] <= mean;
        changed     <= 1'b1;
      end
      if (cmd.sort) begin
        c[0] <= t0;
        c[1] <= t1;
        c[2] <= t2;
      end
    end
  end

  // classification
  logic [khc_pkg::WORD_W-1:0] ca, cb, ccd;
  logic [1:0]                 cls;

  always_comb begin
    ca  = khc_pkg::absdiff32(sample_value, khc_pkg::WORD_W'(c[0]));
    cb  = khc_pkg::absdiff32(sample_value, khc_pkg::WORD_W'(c[1]));
    ccd = khc_pkg::absdiff32(sample_value, khc_pkg::WORD_W'(c[2]));
    if (kc3) begin
      if (ca < cb) begin
        cls = (ca < ccd) ? khc_pkg::TEMP_HOT : khc_pkg::TEMP_COLD;
      end else begin
        cls = (ccd > cb) ? khc_pkg::TEMP_WARM : khc_pkg::TEMP_COLD;
      end
    end else begin
      cls = (ca < cb) ? khc_pkg::TEMP_HOT : khc_pkg::TEMP_WARM;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (cmd.emit) begin
        result_valid <= 1'b1;
      end else if (accept && mode == khc_pkg::MODE_CLASSIFY) begin
        result_valid <= 1'b1;
      end else if (accept && mode == khc_pkg::MODE_RUN && count == '0) begin
        result_valid <= 1'b1;
      end
    end
    result_kind       <= khc_pkg::KIND_ERROR;
    center_value      <= '0;
    center_slot       <= '0;
    temperature_class <= '0;
    rounds_used       <= '0;
    last              <= 1'b1;
    if (cmd.emit) begin
      result_kind  <= khc_pkg::KIND_CENTER;
      center_value <= c[cmd.slot];
      center_slot  <= cmd.slot;
      rounds_used  <= 10'(rounds);
      last         <= cmd.slot == (kc3 ? 2'd2 : 2'd1);
    end else if (accept && mode == khc_pkg::MODE_CLASSIFY) begin
      result_kind       <= khc_pkg::KIND_CLASS;
      temperature_class <= cls;
    end
  end

  // status to the sequencer
  always_comb begin
    sts              = '0;
    sts.count_zero   = count == '0;
    sts.div_done     = div_done;
    sts.pass_done    = pass_done;
    sts.total_zero   = total == '0;
    sts.members_zero = {members[2] == '0, members[1] == '0, members[0] == '0};
    sts.changed      = changed;
    sts.round_limit  = rounds == RW'(MAX_ROUNDS);
    sts.kc3          = kc3;
  end
endmodule
`default_nettype wire

// ===== hdl/one_dim_kmeans_hotness_classifier.sv =====
// Top level: 1-D k-means hotness classifier, sequencer plus datapath.
// Load: one beat per cycle while not busy, no result. Classify: result in the cycle after accept.
// Run with k centers: seeding, then refinement rounds, each one assign pass over the store
// plus one mean division per non-empty cluster (one shared 64-step divider, one store
// read port), then a sort and k result beats; busy high throughout.
// Synchronous active-high reset clears the store count, centers and control.
`default_nettype none
module one_dim_kmeans_hotness_classifier #(
  parameter int MAX_SAMPLES = 4096,
  parameter int MAX_ROUNDS  = 1000
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [1:0]                 mode,
  input  wire logic [khc_pkg::WORD_W-1:0] sample_value,
  input  wire logic [khc_pkg::RAND_W-1:0] rand_first,
  input  wire logic [khc_pkg::RAND_W-1:0] rand_second,
  input  wire logic [khc_pkg::RAND_W-1:0] rand_third,
  input  wire logic                       cfg_we,
  input  wire logic [1:0]                 cfg_data,
  output logic                            result_valid,
  output logic [1:0]                      result_kind,
  output logic [khc_pkg::VAL_W-1:0]       center_value,
  output logic [1:0]                      center_slot,
  output logic [1:0]                      temperature_class,
  output logic [9:0]                      rounds_used,
  output logic                            last
);
  khc_pkg::khc_cmd_t    cmd;
  khc_pkg::khc_status_t sts;

  khc_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .mode (mode),
    .sts  (sts),
    .cmd  (cmd),
    .busy (busy)
  );

  khc_dp #(.MAX_SAMPLES(MAX_SAMPLES), .MAX_ROUNDS(MAX_ROUNDS)) u_dp (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .mode             (mode),
    .sample_value     (sample_value),
    .rand_first       (rand_first),
    .rand_second      (rand_second),
    .rand_third       (rand_third),
    .cfg_we           (cfg_we),
    .cfg_data         (cfg_data),
    .cmd              (cmd),
    .sts              (sts),
    .result_valid     (result_valid),
    .result_kind      (result_kind),
    .center_value     (center_value),
    .center_slot      (center_slot),
    .temperature_class(temperature_class),
    .rounds_used      (rounds_used),
    .last             (last)
  );
endmodule
`default_nettype wire

// ===== hdl/khc_checker.sv =====
// Port-level checks for the classifier, bound to the top level.
`default_nettype none
module khc_port_checks (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      start,
  input wire logic                      busy,
  input wire logic [1:0]                mode,
  input wire logic                      result_valid,
  input wire logic [1:0]                result_kind,
  input wire logic [khc_pkg::VAL_W-1:0] center_value,
  input wire logic [1:0]                center_slot,
  input wire logic                      last
);
  // an error beat is always the only beat of its item
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_kind == khc_pkg::KIND_ERROR |-> last)
    else $error("error beat without last");

  // classify answers in the next cycle
  a_class: assert property (@(posedge clk) disable iff (rst)
    start && !busy && mode == khc_pkg::MODE_CLASSIFY |=>
      result_valid && result_kind == khc_pkg::KIND_CLASS && last)
    else $error("classify beat missing");

  // centers come out back to back in ascending order
  a_sorted: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_kind == khc_pkg::KIND_CENTER && center_slot != 2'd0 |->
      $past(result_valid) && center_value >= $past(center_value))
    else $error("centers out of order");

  // a load never produces a beat
  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    start && !busy && mode == khc_pkg::MODE_LOAD |=> !result_valid)
    else $error("beat after load");
endmodule

bind one_dim_kmeans_hotness_classifier khc_port_checks u_khc_port_checks (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .mode        (mode),
  .result_valid(result_valid),
  .result_kind (result_kind),
  .center_value(center_value),
  .center_slot (center_slot),
  .last        (last)
);
`default_nettype wire

// ===== dv/khc_checker.sv =====
// Scoreboard for the hotness classifier: predicts centers and classes, compares result beats.
`timescale 1ns / 100ps
module khc_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  mode,
  input  logic [31:0] sample_value,
  input  logic [63:0] rand_first,
  input  logic [63:0] rand_second,
  input  logic [63:0] rand_third,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_data,
  input  logic        result_valid,
  input  logic [1:0]  result_kind,
  input  logic [29:0] center_value,
  input  logic [1:0]  center_slot,
  input  logic [1:0]  temperature_class,
  input  logic [9:0]  rounds_used,
  input  logic        last,
  output int          fail_count,
  output int          pending
);
  localparam int STORE_DEPTH = 4096;
  localparam int ROUND_LIMIT = 1000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [29:0] value;
    logic [1:0]  slot;
    logic [1:0]  temp;
    logic [9:0]  rounds;
    logic        fin;
  } result_beat_t;

  result_beat_t expected_beats[$];

  bit [29:0] samples[STORE_DEPTH];
  bit [31:0] seed_dist[STORE_DEPTH];
  int        sample_total;
  bit [29:0] centers[3];
  int        cluster_limit;
  int        errors;

  function automatic bit [31:0] gap32(bit [31:0] a, bit [31:0] b);
    return (a < b) ? b - a : a - b;
  endfunction

  function automatic result_beat_t beat_of(logic [1:0] kind, logic [29:0] value,
                                           logic [1:0] slot, logic [1:0] temp,
                                           logic [9:0] rounds, logic fin);
    result_beat_t b;
    b.kind = kind; b.value = value; b.slot = slot;
    b.temp = temp; b.rounds = rounds; b.fin = fin;
    return b;
  endfunction

  // Seed, refine and sort the centers, then queue one beat per center (an error beat if no samples are held).
  task automatic cluster_centers(bit [63:0] r0, bit [63:0] r1, bit [63:0] r2);
    bit [63:0]  rnd[3];
    bit [63:0]  total, thr, acc;
    bit [63:0]  sums[3];
    int         members[3];
    bit [31:0]  d, best, mean;
    bit [29:0]  t;
    int         pick, pos, rounds;
    bit         seeded, changed;
    rnd[0] = r0; rnd[1] = r1; rnd[2] = r2;
    if (sample_total == 0) begin
      expected_beats.push_back(beat_of(khc_pkg::KIND_ERROR, '0, '0, '0, '0, 1'b1));
      return;
    end
    centers[0] = samples[r0 % sample_total];
    seeded = 0;
    for (int k = 1; k < cluster_limit && !seeded; k++) begin
      total = 0;
      for (int j = 0; j < sample_total; j++) begin
        d = 0;
        for (int i = 0; i < k; i++) d += gap32(centers[i], samples[j]);
        seed_dist[j] = d;
        total += d;
      end
      if (total == 0) begin
        for (int i = 1; i < cluster_limit; i++) centers[i] = centers[0];
        seeded = 1;
      end else begin
        thr = rnd[k] % total;
        acc = 0;
        pick = sample_total - 1;
        for (int j = 0; j < sample_total; j++) begin
          acc += seed_dist[j];
          if (acc >= thr) begin
            pick = j;
            break;
          end
        end
        centers[k] = samples[pick];
      end
    end
    // Lloyd rounds: reassign, then move non-empty clusters to their truncated mean.
    rounds = 0;
    changed = 1;
    while (changed && rounds < ROUND_LIMIT) begin
      changed = 0;
      rounds++;
      for (int i = 0; i < 3; i++) begin
        sums[i] = 0;
        members[i] = 0;
      end
      for (int j = 0; j < sample_total; j++) begin
        best = gap32(centers[0], samples[j]);
        pos = 0;
        for (int i = 1; i < cluster_limit; i++) begin
          d = gap32(centers[i], samples[j]);
          if (d < best) begin
            best = d;
            pos = i;
          end
        end
        sums[pos] += samples[j];
        members[pos]++;
      end
      for (int i = 0; i < cluster_limit; i++) begin
        if (members[i] != 0) begin
          mean = 32'(sums[i] / members[i]);
          if (mean != 32'(centers[i])) begin
            changed = 1;
            centers[i] = mean[29:0];
          end
        end
      end
    end
    for (int i = 0; i < cluster_limit - 1; i++)
      for (int j = 0; j < cluster_limit - 1 - i; j++)
        if (centers[j] > centers[j+1]) begin
          t = centers[j];
          centers[j] = centers[j+1];
          centers[j+1] = t;
        end
    if (cluster_limit == 2) centers[2] = khc_pkg::SAMPLE_ALL_ONES;
    for (int i = 0; i < cluster_limit; i++)
      expected_beats.push_back(beat_of(khc_pkg::KIND_CENTER, centers[i], 2'(i),
                                       khc_pkg::TEMP_HOT, 10'(rounds),
                                       i == cluster_limit - 1));
    sample_total = 0;
  endtask

  function automatic logic [1:0] temperature_of(bit [31:0] word);
    bit [31:0] a, b, c;
    a = gap32(word, centers[0]);
    b = gap32(word, centers[1]);
    c = gap32(word, centers[2]);
    if (cluster_limit == 3) begin
      if (a < b) return (a < c) ? khc_pkg::TEMP_HOT : khc_pkg::TEMP_COLD;
      return (c > b) ? khc_pkg::TEMP_WARM : khc_pkg::TEMP_COLD;
    end
    return (a < b) ? khc_pkg::TEMP_HOT : khc_pkg::TEMP_WARM;
  endfunction

  always @(posedge clk) begin
    result_beat_t got, want;
    bit [29:0]    s;
    if (rst) begin
      sample_total = 0;
      centers = '{default: '0};
      cluster_limit = 2;
      expected_beats.delete();
    end else begin
      // Track the cluster count register.
      if (cfg_we) cluster_limit = (cfg_data == 2'd3) ? 3 : 2;
      // Compare the result beat with the oldest expectation.
      if (result_valid) begin
        got = beat_of(result_kind, center_value, center_slot, temperature_class,
                      rounds_used, last);
        if (expected_beats.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat, expected none actual %p", $time, got);
        end else begin
          want = expected_beats.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: result mismatch expected %p actual %p", $time, want, got);
          end
        end
      end
      // Predict the accepted command.
      if (start && !busy) begin
        case (mode)
          khc_pkg::MODE_LOAD: begin
            s = sample_value[31:2];
            if (s != 0 && s != khc_pkg::SAMPLE_ALL_ONES && sample_total < STORE_DEPTH) begin
              samples[sample_total] = s;
              sample_total++;
            end
          end
          khc_pkg::MODE_RUN: cluster_centers(rand_first, rand_second, rand_third);
          khc_pkg::MODE_CLASSIFY: expected_beats.push_back(beat_of(khc_pkg::KIND_CLASS,
                                    '0, '0, temperature_of(sample_value), '0, 1'b1));
          default: ;
        endcase
      end
    end
    pending <= expected_beats.size();
    fail_count <= errors;
  end

  initial begin
    errors = 0;
    pending = 0;
    fail_count = 0;
    cluster_limit = 2;
    sample_total = 0;
  end
endmodule

// ===== dv/testbench.sv =====
// Stimulus and verdict for the 1-D k-means hotness classifier.
`timescale 1ns / 100ps
module testbench;
  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  logic [1:0]  mode = khc_pkg::MODE_LOAD;
  logic [31:0] sample_value = '0;
  logic [63:0] rand_first = '0;
  logic [63:0] rand_second = '0;
  logic [63:0] rand_third = '0;
  logic        cfg_we = 0;
  logic [1:0]  cfg_data = '0;
  logic        busy, result_valid, last;
  logic [1:0]  result_kind, center_slot, temperature_class;
  logic [29:0] center_value;
  logic [9:0]  rounds_used;
  int          fail_count, pending;
  int          loads_sent, runs_sent, classifies_sent;
  bit          no_gaps;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  one_dim_kmeans_hotness_classifier u_top (
    .clk, .rst, .start, .busy, .mode, .sample_value, .rand_first, .rand_second,
    .rand_third, .cfg_we, .cfg_data, .result_valid, .result_kind, .center_value,
    .center_slot, .temperature_class, .rounds_used, .last
  );

  khc_checker u_checker (
    .clk, .rst, .start, .busy, .mode, .sample_value, .rand_first, .rand_second,
    .rand_third, .cfg_we, .cfg_data, .result_valid, .result_kind, .center_value,
    .center_slot, .temperature_class, .rounds_used, .last, .fail_count, .pending
  );

  // Hold the command until the block is not busy and takes it.
  task automatic issue(logic [1:0] m, logic [31:0] word, logic [63:0] r0 = '0,
                       logic [63:0] r1 = '0, logic [63:0] r2 = '0);
    start <= 1;
    mode <= m;
    sample_value <= word;
    rand_first <= r0;
    rand_second <= r1;
    rand_third <= r2;
    do @(posedge clk); while (busy);
    case (m)
      khc_pkg::MODE_LOAD: loads_sent++;
      khc_pkg::MODE_RUN: runs_sent++;
      khc_pkg::MODE_CLASSIFY: classifies_sent++;
      default: ;
    endcase
  endtask

  // Drop start for a random gap (often none), mostly short, a few long.
  task automatic idle_gap();
    int r, n;
    r = $urandom_range(0, 99);
    n = (no_gaps || r < 60) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(5, 30);
    if (n > 0) begin
      start <= 0;
      mode <= 2'($urandom);
      sample_value <= $urandom;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain(int tail);
    start <= 0;
    do @(posedge clk); while (pending != 0 || busy);
    repeat (tail) @(posedge clk);
  endtask

  task automatic set_clusters(logic [1:0] v);
    cfg_we <= 1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 50);
      1: return '1 - $urandom_range(0, 3);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [31:0] load_word();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return $urandom_range(0, 3);
    if (r == 1) return 32'hFFFF_FFFF - $urandom_range(0, 3);
    if (r < 11) return {30'($urandom_range(1, 4000)), 2'($urandom)};
    return $urandom;
  endfunction

  initial begin
    int nload, nclass;
    no_gaps = 0;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: classify against reset centers, empty run, dropped loads.
    issue(khc_pkg::MODE_CLASSIFY, 32'h0);
    issue(khc_pkg::MODE_CLASSIFY, 32'hFFFF_FFFF);
    issue(khc_pkg::MODE_RUN, 32'h0, '1, '1, '1);
    issue(khc_pkg::MODE_LOAD, 32'h0000_0003);
    issue(khc_pkg::MODE_LOAD, 32'hFFFF_FFFF);
    issue(khc_pkg::MODE_LOAD, 32'hFFFF_FFFC);
    issue(khc_pkg::MODE_RUN, 32'h0);
    drain(8);
    // Identical samples give zero seeding distance; classify ties everywhere.
    set_clusters(2'd3);
    issue(khc_pkg::MODE_LOAD, 32'd400);
    issue(khc_pkg::MODE_LOAD, 32'd401);
    issue(khc_pkg::MODE_RUN, 32'h0, 64'd7, '1, '0);
    issue(khc_pkg::MODE_CLASSIFY, 32'd100);
    issue(khc_pkg::MODE_CLASSIFY, 32'd0);
    drain(8);
    set_clusters(2'd2);
    issue(khc_pkg::MODE_CLASSIFY, 32'd100);
    // Spread samples, three clusters, then two, with extreme sample values.
    drain(8);
    set_clusters(2'd3);
    issue(khc_pkg::MODE_LOAD, 32'd4);
    issue(khc_pkg::MODE_LOAD, 32'hFFFF_FFF8);
    issue(khc_pkg::MODE_LOAD, 32'h8000_0000);
    issue(khc_pkg::MODE_LOAD, 32'd40);
    issue(khc_pkg::MODE_RUN, 32'h0, '1, '0, '1);
    issue(khc_pkg::MODE_CLASSIFY, 32'h4000_0000);
    issue(2'd3, 32'h1234_5678);
    drain(8);
    set_clusters(2'd0);
    issue(khc_pkg::MODE_LOAD, 32'd8);
    issue(khc_pkg::MODE_LOAD, 32'hFFFF_FFF4);
    issue(khc_pkg::MODE_RUN, 32'h0, 64'd1, 64'd0, 64'd0);
    issue(khc_pkg::MODE_CLASSIFY, 32'h7FFF_FFFF);
    drain(8);
    set_clusters(2'd1);

    // Random phases: load a batch, cluster it, classify against it.
    while (loads_sent + runs_sent + classifies_sent < 155) begin
      drain(8);
      set_clusters(2'($urandom));
      no_gaps = ($urandom_range(0, 3) == 0);
      nload = $urandom_range(0, 12);
      repeat (nload) begin
        issue(khc_pkg::MODE_LOAD, load_word());
        idle_gap();
      end
      issue(khc_pkg::MODE_RUN, $urandom, rand_word(), rand_word(), rand_word());
      idle_gap();
      nclass = $urandom_range(0, 5);
      repeat (nclass) begin
        issue(khc_pkg::MODE_CLASSIFY,
              ($urandom_range(0, 1) == 0) ? $urandom
                                          : {30'($urandom_range(0, 4100)), 2'b0});
        idle_gap();
      end
      if ($urandom_range(0, 9) == 0) issue(2'd3, $urandom);
    end
    drain(50);

    $display("Covered %0d loads, %0d runs, %0d classifies",
             loads_sent, runs_sent, classifies_sent);
    $display("with two and three clusters, empty runs and tie cases; %0d failures",
             fail_count);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("FAIL");
    $finish;
  end
endmodule
